// ===== hdl/pur_pkg.sv =====
package pur_pkg;

   // frame phases of one receive channel
   localparam logic [3:0] PHASE_IDLE       = 4'd0;
   localparam logic [3:0] PHASE_START      = 4'd1;
   localparam logic [3:0] PHASE_FIRST_DATA = 4'd2;
   localparam logic [3:0] PHASE_STOP       = 4'd10;

   // item kinds carried in req_tuser
   localparam logic OP_POLL = 1'b0;
   localparam logic OP_TAKE = 1'b1;

   // bit period registers, one per channel slot
   localparam int NUM_PERIOD_REGS = 4;
   localparam logic [15:0] PERIOD_RESET = 16'd104;

   typedef logic [NUM_PERIOD_REGS-1:0][15:0] period_array_type;

   // one request item
   typedef struct packed {
      logic        op;
      logic [1:0]  channel;
      logic [31:0] now;
      logic        line_level;
   } req_type;

   // one result item, last field in the lowest bits
   typedef struct packed {
      logic       start_glitch;
      logic       frame_error;
      logic       byte_done;
      logic [7:0] rx_byte;
      logic       data_waiting;
   } rsp_type;

endpackage

// ===== hdl/pur_period_regs.sv =====
module pur_period_regs (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [1:0]                wr_index,
   input  logic [15:0]               wr_data,
   output pur_pkg::period_array_type periods
);

   pur_pkg::period_array_type period_ff;

   // bit period per channel, written from the csr port
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pur_pkg::NUM_PERIOD_REGS; i++) begin
            period_ff[i] <= pur_pkg::PERIOD_RESET;
         end
      end else if (wr_en) begin
         period_ff[wr_index] <= wr_data;
      end
   end

   assign periods = period_ff;

endmodule

// ===== hdl/pur_rx_state.sv =====
module pur_rx_state #(
   parameter int CHANNELS  = 4,
   parameter int TIME_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  pur_pkg::req_type          req,
   input  pur_pkg::period_array_type periods,
   output pur_pkg::rsp_type          rsp
);

   localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // per-channel receive state
   logic [3:0]           phase_ff [CHANNELS];
   logic [7:0]           shift_ff [CHANNELS];
   logic [TIME_BITS-1:0] nst_ff   [CHANNELS];
   logic [7:0]           held_ff  [CHANNELS];
   logic                 wait_ff  [CHANNELS];

   logic [ChIdxW-1:0]    idx;
   logic                 ch_ok;
   logic [15:0]          period;
   logic [TIME_BITS-1:0] now_t;
   logic [3:0]           phase_in;
   logic [7:0]           shift_in;
   logic [TIME_BITS-1:0] nst_in;
   logic [7:0]           held_in;
   logic                 wait_in;
   logic                 done;
   logic                 ferr;
   logic                 glitch;

   assign idx    = req.channel[ChIdxW-1:0];
   assign ch_ok  = 32'(req.channel) < CHANNELS;
   assign period = periods[req.channel];
   assign now_t  = TIME_BITS'(req.now);

   // next state of the addressed channel
   always_comb begin
      phase_in = phase_ff[idx];
      shift_in = shift_ff[idx];
      nst_in   = nst_ff[idx];
      held_in  = held_ff[idx];
      wait_in  = wait_ff[idx];
      done     = 1'b0;
      ferr     = 1'b0;
      glitch   = 1'b0;
      if (req.op == pur_pkg::OP_TAKE) begin
         wait_in = 1'b0;
      end else if (phase_ff[idx] == pur_pkg::PHASE_IDLE) begin
         // falling line starts a frame, first sample at mid start bit
         if (!req.line_level) begin
            phase_in = pur_pkg::PHASE_START;
            nst_in   = now_t + TIME_BITS'(period >> 1);
            shift_in = 8'h00;
         end
      end else if (now_t >= nst_ff[idx]) begin
         nst_in = nst_ff[idx] + TIME_BITS'(period);
         if (phase_ff[idx] == pur_pkg::PHASE_START) begin
            if (!req.line_level) begin
               phase_in = pur_pkg::PHASE_FIRST_DATA;
            end else begin
               phase_in = pur_pkg::PHASE_IDLE;
               glitch   = 1'b1;
            end
         end else if (phase_ff[idx] >= pur_pkg::PHASE_FIRST_DATA &&
                      phase_ff[idx] < pur_pkg::PHASE_STOP) begin
            // data bits arrive lsb first
            shift_in = {req.line_level, shift_ff[idx][7:1]};
            phase_in = phase_ff[idx] + 4'd1;
         end else if (phase_ff[idx] == pur_pkg::PHASE_STOP) begin
            if (req.line_level) begin
               held_in = shift_ff[idx];
               wait_in = 1'b1;
               done    = 1'b1;
            end else begin
               ferr = 1'b1;
            end
            phase_in = pur_pkg::PHASE_IDLE;
         end else begin
            phase_in = pur_pkg::PHASE_IDLE;
         end
      end
   end

   // result of this item, all zero for a channel not present
   always_comb begin
      rsp = '0;
      if (ch_ok) begin
         rsp.data_waiting = (req.op == pur_pkg::OP_TAKE) ? wait_ff[idx] : wait_in;
         rsp.rx_byte      = held_in;
         rsp.byte_done    = done;
         rsp.frame_error  = ferr;
         rsp.start_glitch = glitch;
      end
   end

   // state update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            phase_ff[i] <= pur_pkg::PHASE_IDLE;
            shift_ff[i] <= 8'h00;
            nst_ff[i]   <= '0;
            held_ff[i]  <= 8'h00;
            wait_ff[i]  <= 1'b0;
         end
      end else if (step_en && ch_ok) begin
         phase_ff[idx] <= phase_in;
         shift_ff[idx] <= shift_in;
         nst_ff[idx]   <= nst_in;
         held_ff[idx]  <= held_in;
         wait_ff[idx]  <= wait_in;
      end
   end

endmodule

// ===== hdl/polled_uart_receiver_unit.sv =====
// channel | direction | handshake            | payload
// req     | in        | req_tvalid/req_tready | tuser: op, channel; tdata: now, line_level
// rsp     | out       | rsp_tvalid/rsp_tready | tdata: data_waiting, rx_byte, flags
// csr     | in        | csr_valid/csr_ready   | csr_index, csr_data (bit period)
//
// Each item passes an input register, then the channel state update and the
// result register in the same cycle. One item is accepted per cycle while rsp
// is not stalled; back-to-back items on one channel see the state left by the
// previous item. Reset is synchronous and clears all channel state and
// restores every bit period to 104. A stalled rsp holds its item while
// one more item waits in the input register; csr_ready is always high.
module polled_uart_receiver_unit #(
   parameter int CHANNELS  = 4,
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // now[31:0], line_level[32], zero fill
   input  logic [2:0]  req_tuser,   // op[0], channel[2:1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // data_waiting[0], rx_byte[8:1], byte_done[9],
                                    // frame_error[10], start_glitch[11], zero fill
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   pur_pkg::req_type          req_ff;
   pur_pkg::req_type          req_in;
   logic                      req_vld_ff;
   pur_pkg::rsp_type          rsp_ff;
   pur_pkg::rsp_type          rsp_in;
   logic                      rsp_vld_ff;
   logic                      advance;
   logic                      req_fire;
   pur_pkg::period_array_type periods;

   assign csr_ready = 1'b1;

   pur_period_regs u_periods (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .periods  (periods)
   );

   // handshake: input stage moves into the result register when it is free
   assign advance    = req_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !req_vld_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   // unpack the request item
   always_comb begin
      req_in.op         = req_tuser[0];
      req_in.channel    = req_tuser[2:1];
      req_in.now        = req_tdata[31:0];
      req_in.line_level = req_tdata[32];
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req_tready) begin
         req_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_in;
      end
   end

   pur_rx_state #(
      .CHANNELS  (CHANNELS),
      .TIME_BITS (TIME_BITS)
   ) u_state (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (req_ff),
      .periods (periods),
      .rsp     (rsp_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (!rsp_vld_ff || rsp_tready) begin
         rsp_vld_ff <= req_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'b0000, rsp_ff};

endmodule

// ===== hdl/pur_checker.sv =====
module pur_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // a stalled item stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // one poll ends at most one frame element
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[11:9]))
      else $error("more than one frame flag set");

   // a stored byte is waiting
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |-> rsp_tdata[0])
      else $error("byte done without data waiting");

endmodule

bind polled_uart_receiver_unit pur_checker u_pur_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
